/* rtl/core/rpi_pkg.sv */
// ---------------------------------------------------------------------------
// rpi_pkg
// Shared types, constants and helpers of the RGB555 palette indexer.
// ---------------------------------------------------------------------------
package rpi_pkg;

   // Palette RAM depth, key entry slot included.
   localparam int PAL_ENTRIES = 256;
   localparam int PAL_AW      = $clog2(PAL_ENTRIES);
   localparam int COLOR_W     = 15;

   // Reset value of the key color (#ff00ff in BGR555).
   localparam logic [COLOR_W-1:0] KEY_RESET = 15'h7C1F;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOR    = 1'd1;

   // Operation codes.
   localparam logic OP_CONVERT  = 1'b0;
   localparam logic OP_READBACK = 1'b1;

   typedef struct packed {
      logic       operation;
      logic       start_of_image;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] entry_select;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color_word;
      logic [7:0]         palette_index;
      logic               newly_added;
      logic               palette_overflow;
   } rsp_type;

   typedef struct packed {
      logic               palette_mode;
      logic [COLOR_W-1:0] key_color;
   } cfg_type;

   // Keeps the top five bits of each channel: blue high, red low.
   function automatic logic [COLOR_W-1:0] pack_bgr555(input logic [7:0] r,
                                                      input logic [7:0] g,
                                                      input logic [7:0] b);
      return {b[7:3], g[7:3], r[7:3]};
   endfunction

endpackage

/* rtl/core/rpi_ram.sv */
// ---------------------------------------------------------------------------
// rpi_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module rpi_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rpi_csr.sv */
// ---------------------------------------------------------------------------
// rpi_csr
// Configuration registers: palette mode and transparent key color.
// ---------------------------------------------------------------------------
module rpi_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rpi_pkg::COLOR_W-1:0]   csr_wdata,
   output rpi_pkg::cfg_type              cfg
);

   rpi_pkg::cfg_type cfg_ff;
   rpi_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rpi_pkg::CSR_PALETTE_MODE: cfg_in.palette_mode = csr_wdata[0];
            rpi_pkg::CSR_KEY_COLOR:    cfg_in.key_color    = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.palette_mode <= 1'b0;
         cfg_ff.key_color    <= rpi_pkg::KEY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/rpi_engine.sv */
// ---------------------------------------------------------------------------
// rpi_engine
// Transaction sequencer: direct conversion, palette search, append and readback over the RAM.
// ---------------------------------------------------------------------------
module rpi_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  rpi_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rpi_pkg::req_type            req_data,
   output logic                        res_valid,
   input  logic                        res_ready,
   output rpi_pkg::rsp_type            res_data,
   // palette RAM ports
   output logic                        ram_wr_en,
   output logic [rpi_pkg::PAL_AW-1:0]  ram_wr_addr,
   output logic [rpi_pkg::COLOR_W-1:0] ram_wr_data,
   output logic [rpi_pkg::PAL_AW-1:0]  ram_rd_addr,
   input  logic [rpi_pkg::COLOR_W-1:0] ram_rd_data
);

   localparam int AW = rpi_pkg::PAL_AW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_KEY,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               used_ff, used_in;
   logic [AW-1:0]               ptr_ff, ptr_in;
   logic [rpi_pkg::COLOR_W-1:0] key_entry_ff, key_entry_in;
   logic [rpi_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [7:0]                  sel_ff, sel_in;
   rpi_pkg::rsp_type            res_ff, res_in;

   logic          accept;
   logic          miss;
   logic [AW:0]   ptr_next;
   logic          full;
   logic          sel_in_use;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign ptr_next = {1'b0, ptr_ff} + 1'b1;
   assign full     = ({1'b0, used_ff} >= (AW + 1)'(rpi_pkg::PAL_ENTRIES - 1));
   assign sel_in_use = ({1'b0, sel_ff} < 9'({1'b0, used_ff}))
                    && ({1'b0, sel_ff} < 9'(rpi_pkg::PAL_ENTRIES));

   // A miss ends the search without a match: after the key when only the
   // key is in use, or at the last entry in use.
   always_comb begin
      miss = 1'b0;
      case (state_ff)
         ST_KEY:    miss = (color_ff != key_entry_ff) && (used_ff == AW'(1));
         ST_SEARCH: miss = (ram_rd_data != color_ff) && (ptr_next == {1'b0, used_ff});
         default:   miss = 1'b0;
      endcase
   end

   assign ram_wr_en   = miss && !full;
   assign ram_wr_addr = used_ff;
   assign ram_wr_data = color_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE:   ram_rd_addr = req_data.entry_select[AW-1:0];
         ST_KEY:    ram_rd_addr = AW'(1);
         ST_SEARCH: ram_rd_addr = ptr_next[AW-1:0];
         default:   ram_rd_addr = ptr_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      ptr_in       = ptr_ff;
      key_entry_in = key_entry_ff;
      color_in     = color_ff;
      sel_in       = sel_ff;
      res_in       = res_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               color_in = rpi_pkg::pack_bgr555(req_data.red, req_data.green, req_data.blue);
               sel_in   = req_data.entry_select;
               if (req_data.start_of_image) begin
                  used_in      = AW'(1);
                  key_entry_in = cfg.key_color;
               end
               res_in.color_word       = color_in;
               res_in.palette_index    = 8'd0;
               res_in.newly_added      = 1'b0;
               res_in.palette_overflow = 1'b0;
               if (req_data.operation == rpi_pkg::OP_READBACK) begin
                  state_in = ST_READ;
               end else if (cfg.palette_mode) begin
                  state_in = ST_KEY;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            res_in.palette_index = sel_ff;
            if (!sel_in_use) begin
               res_in.color_word = '0;
            end else if (sel_ff == 8'd0) begin
               res_in.color_word = key_entry_ff;
            end else begin
               res_in.color_word = ram_rd_data;
            end
            state_in = ST_DONE;
         end
         ST_KEY: begin
            if (color_ff == key_entry_ff) begin
               state_in = ST_DONE;
            end else if (!miss) begin
               ptr_in   = AW'(1);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (ram_rd_data == color_ff) begin
               res_in.palette_index = 8'(ptr_ff);
               state_in             = ST_DONE;
            end else if (!miss) begin
               ptr_in = ptr_next[AW-1:0];
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (miss) begin
         state_in = ST_DONE;
         if (full) begin
            res_in.palette_overflow = 1'b1;
         end else begin
            res_in.palette_index = 8'(used_ff);
            res_in.newly_added   = 1'b1;
            used_in              = used_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= AW'(1);
         ptr_ff       <= '0;
         key_entry_ff <= rpi_pkg::KEY_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ptr_ff       <= ptr_in;
         key_entry_ff <= key_entry_in;
      end
      color_ff <= color_in;
      sel_ff   <= sel_in;
      res_ff   <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

endmodule

/* rtl/core/rgb555_palette_indexer_top.sv */
// ---------------------------------------------------------------------------
// rgb555_palette_indexer_top
// Packs RGB888 pixels into BGR555 and maps them to a growing palette.
// ---------------------------------------------------------------------------
// Usage:
// Input transactions arrive on req_valid/req_ready with a req_data struct.
// A convert transaction packs the pixel into BGR555; in palette mode it also
// looks the color up in the palette, appending it when new and room is left.
// A readback transaction returns one stored palette entry. Results leave on
// rsp_valid/rsp_ready, one per input transaction, in order.
// One transaction is processed at a time. Direct mode goes from acceptance
// straight to the result state, readback passes through a read state, and a
// palette lookup compares the key first and then the non-key entries in use,
// of which a full palette holds 254 beside the key. The search reads one
// entry per cycle through the single read port of the palette RAM.
// An output register decouples the result side: while a result waits for
// rsp_ready, the engine may already accept and process the next transaction
// up to its own result, then it holds until the output register drains.
// Reset restores palette_mode 0, the key color #ff00ff and a palette that
// holds only the key; the RAM itself is not cleared, entries beyond the fill
// count simply read as zero, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module rgb555_palette_indexer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rpi_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rpi_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [rpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rpi_pkg::COLOR_W-1:0]   csr_wdata
);

   rpi_pkg::cfg_type             cfg;
   logic                         res_valid;
   logic                         res_ready;
   rpi_pkg::rsp_type             res_data;
   logic                         ram_wr_en;
   logic [rpi_pkg::PAL_AW-1:0]   ram_wr_addr;
   logic [rpi_pkg::COLOR_W-1:0]  ram_wr_data;
   logic [rpi_pkg::PAL_AW-1:0]   ram_rd_addr;
   logic [rpi_pkg::COLOR_W-1:0]  ram_rd_data;

   logic                         rsp_valid_ff, rsp_valid_in;
   rpi_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
   rpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Palette store. Entry zero is never used from the RAM: the engine keeps
   // the key entry in a register so that a start of image reloads it at once.
   rpi_ram #(
      .WIDTH (rpi_pkg::COLOR_W),
      .DEPTH (rpi_pkg::PAL_ENTRIES)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rpi_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // The output register takes a new result whenever it is empty or its
   // current result is leaving in this cycle.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/rpi_check.sv */
// ---------------------------------------------------------------------------
// rpi_check
// Port-level assertions for the palette indexer, bound to the top level.
// ---------------------------------------------------------------------------
module rpi_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rpi_pkg::rsp_type rsp_data
);

   // No result is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // The block works on one transaction at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

   // An append never also reports overflow.
   a_added_not_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.newly_added |-> !rsp_data.palette_overflow)
      else $error("append and overflow reported together");

   // An appended color never lands on the key entry.
   a_added_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.newly_added |-> rsp_data.palette_index != 8'd0)
      else $error("appended color reported at key entry");

endmodule

bind rgb555_palette_indexer_top rpi_check u_rpi_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB555 palette indexer. A palette tracker class
// predicts every result from the accepted input transactions and compares the
// block's output against it field by field. The stimulus has two parts. A
// short directed part covers channel extremes, readback and key changes. A
// random part follows with image phases: most use small color pools, two fill
// the palette past overflow, and both sides of the handshake idle at random.
// ---------------------------------------------------------------------------
module testbench;
   import rpi_pkg::*;

   // Tracks palette contents and configuration. Holds the results still
   // owed by the block, oldest first.
   class palette_tracker;
      logic [COLOR_W-1:0] entry [PAL_ENTRIES];
      int unsigned        used;
      logic               mode;
      logic [COLOR_W-1:0] key;
      rsp_type            awaited [$];
      int unsigned        errors;

      function new();
         mode   = 1'b0;
         key    = KEY_RESET;
         errors = 0;
         clear_palette();
      endfunction

      function void clear_palette();
         foreach (entry[i]) entry[i] = '0;
         entry[0] = key;
         used     = 1;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
         case (idx)
            CSR_PALETTE_MODE: mode = data[0];
            CSR_KEY_COLOR:    key  = data;
            default: ;
         endcase
      endfunction

      // Works out the result of one accepted transaction and queues it.
      function void note_request(req_type item);
         rsp_type want;
         int      hit;
         want = '0;
         hit  = -1;
         if (item.start_of_image) clear_palette();
         if (item.operation == OP_READBACK) begin
            want.palette_index = item.entry_select;
            if (int'(item.entry_select) < PAL_ENTRIES)
               want.color_word = entry[item.entry_select];
         end else begin
            want.color_word = {item.blue[7:3], item.green[7:3], item.red[7:3]};
            if (mode) begin
               for (int i = 0; i < int'(used) && hit < 0; i++)
                  if (entry[i] == want.color_word) hit = i;
               if (hit >= 0) begin
                  want.palette_index = hit[7:0];
               end else if (used >= PAL_ENTRIES - 1) begin
                  want.palette_overflow = 1'b1;
               end else begin
                  entry[used]        = want.color_word;
                  want.palette_index = used[7:0];
                  want.newly_added   = 1'b1;
                  used++;
               end
            end
         end
         awaited.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("result transaction with nothing outstanding: %h", got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.color_word !== want.color_word) begin
            $error("color_word: expected %h, got %h", want.color_word, got.color_word);
            errors++;
         end
         if (got.palette_index !== want.palette_index) begin
            $error("palette_index: expected %0d, got %0d",
                   want.palette_index, got.palette_index);
            errors++;
         end
         if (got.newly_added !== want.newly_added) begin
            $error("newly_added: expected %b, got %b", want.newly_added, got.newly_added);
            errors++;
         end
         if (got.palette_overflow !== want.palette_overflow) begin
            $error("palette_overflow: expected %b, got %b",
                   want.palette_overflow, got.palette_overflow);
            errors++;
         end
      endfunction
   endclass

   // The limit leaves a wide margin for long searches combined with long stalls.
   localparam int CYCLE_LIMIT  = 3_000_000;
   // The final settle window outlasts a full palette search.
   localparam int DRAIN_CYCLES = 300;
   localparam int ITEM_TARGET  = 1200;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COLOR_W-1:0]   csr_wdata;

   palette_tracker book = new();

   int unsigned cycles    = 0;
   int unsigned sent      = 0;
   // Cycles the receiver still has to hold rsp_ready low, set by the stimulus
   // and counted down by the receiver process.
   int unsigned hold_left = 0;
   // When set, neither side inserts random idle cycles.
   bit          steady    = 1'b0;

   rgb555_palette_indexer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake or an endless search ends the run here.
   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("testbench failed");
      $finish;
   end

   // Result monitor. The outputs are sampled at the rising edge, and
   // rsp_ready only ever changes at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_result(rsp_data);
   end

   // Idle lengths: usually short, rarely long.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Receiver. It stalls at random, and it obeys a long hold-off whenever
   // the stimulus asks for one.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (!steady && $urandom_range(0, 99) < 25) begin
            rsp_ready  = 1'b0;
            stall_left = idle_length() - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Keeps the five bits the block uses and randomizes the three it drops.
   function automatic logic [7:0] jitter(input logic [4:0] top5);
      return {top5, 3'($urandom)};
   endfunction

   // A convert transaction. entry_select is ignored here, so it is random.
   function automatic req_type pixel(input bit soi, input logic [7:0] r, g, b);
      req_type item;
      item.operation      = OP_CONVERT;
      item.start_of_image = soi;
      item.red            = r;
      item.green          = g;
      item.blue           = b;
      item.entry_select   = 8'($urandom);
      return item;
   endfunction

   function automatic req_type pixel_of(input bit soi, input logic [COLOR_W-1:0] col);
      return pixel(soi, jitter(col[4:0]), jitter(col[9:5]), jitter(col[14:10]));
   endfunction

   // A readback transaction. The color channels are ignored, so they are random.
   function automatic req_type readback(input bit soi, input logic [7:0] sel);
      req_type item;
      item.operation      = OP_READBACK;
      item.start_of_image = soi;
      item.red            = 8'($urandom);
      item.green          = 8'($urandom);
      item.blue           = 8'($urandom);
      item.entry_select   = sel;
      return item;
   endfunction

   // Readback targets lean toward the filled part of the palette and just
   // beyond it, with the occasional arbitrary entry.
   function automatic logic [7:0] pick_entry();
      int unsigned top;
      top = (book.used + 2 > 255) ? 255 : book.used + 2;
      if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, top));
      return 8'($urandom);
   endfunction

   // Offers one transaction after an optional random gap. It is called and
   // returns at a falling edge, and it leaves req_valid high, so back-to-back
   // transactions keep valid asserted without a glitch.
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = (steady || $urandom_range(0, 99) >= 30) ? 0 : idle_length();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      book.note_request(item);
      sent++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every owed result has come back. Each
   // transaction yields exactly one result, so the block is idle afterward.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (book.awaited.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [COLOR_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      book.write_reg(idx, data);
   endtask

   // One image: an optional start-of-image, then pixels drawn mostly from a
   // small pool so that lookups hit existing entries. Stray pixels, readbacks
   // and the odd start-of-image in mid-stream are mixed in.
   task automatic run_image(input int unsigned length, input bit fresh);
      logic [COLOR_W-1:0] colors [$];
      logic [COLOR_W-1:0] c;
      int unsigned        k;
      int unsigned        r;
      int unsigned        pool_size;
      bit                 soi;
      pool_size = $urandom_range(1, 40);
      for (k = 0; k < pool_size; k++) begin
         case ($urandom_range(0, 9))
            0:       c = book.key;
            1:       c = '0;
            2:       c = '1;
            default: c = COLOR_W'($urandom);
         endcase
         colors.push_back(c);
      end
      for (k = 0; k < length; k++) begin
         soi = (k == 0) ? fresh : ($urandom_range(0, 99) < 3);
         r   = $urandom_range(0, 99);
         if (r < 15)
            send_item(readback(soi, pick_entry()));
         else if (r < 25)
            send_item(pixel(soi, 8'($urandom), 8'($urandom), 8'($urandom)));
         else
            send_item(pixel_of(soi, colors[$urandom_range(0, colors.size() - 1)]));
      end
   endtask

   // Fills the palette past its limit. An odd stride through the 15-bit color
   // space gives distinct colors, so nearly every pixel appends until the
   // store is full. Repeats of earlier colors and readbacks are mixed in, and
   // they still have to match once the palette has overflowed.
   task automatic run_fill();
      logic [COLOR_W-1:0] base;
      logic [COLOR_W-1:0] step;
      int unsigned        k;
      int unsigned        r;
      base = COLOR_W'($urandom);
      step = {14'($urandom), 1'b1};
      for (k = 0; k < 330; k++) begin
         r = $urandom_range(0, 99);
         if (k != 0 && r < 8)
            send_item(readback(1'b0, pick_entry()));
         else if (k != 0 && r < 16)
            send_item(pixel_of(1'b0, base + COLOR_W'($urandom_range(0, k) * step)));
         else
            send_item(pixel_of(k == 0, base + COLOR_W'(k * step)));
      end
   endtask

   initial begin
      int unsigned        phase;
      bit                 fill;
      logic [COLOR_W-1:0] data;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Direct mode straight out of reset. Channel extremes are covered, a
      // readback of the reset key and of an empty entry, and a start-of-image
      // that does not disturb direct conversion.
      send_item(pixel(1'b0, 8'h00, 8'h00, 8'h00));
      send_item(pixel(1'b0, 8'hFF, 8'hFF, 8'hFF));
      send_item(readback(1'b0, 8'd0));
      send_item(readback(1'b0, 8'hFF));
      send_item(pixel(1'b1, 8'h12, 8'h34, 8'h56));

      // Palette mode. A key hit is followed by a new color and by a match
      // that differs only in the dropped low bits. A second new color is read
      // back, then an untouched entry, then an entry just cleared by a
      // start-of-image on the readback itself.
      wait_idle();
      write_reg(CSR_PALETTE_MODE, 15'd1);
      send_item(pixel(1'b0, 8'hFF, 8'h00, 8'hFF));
      send_item(pixel(1'b0, 8'h00, 8'h00, 8'h00));
      send_item(pixel(1'b0, 8'h07, 8'h07, 8'h07));
      send_item(pixel(1'b0, 8'h80, 8'h40, 8'h20));
      send_item(readback(1'b0, 8'd2));
      send_item(readback(1'b0, 8'd200));
      send_item(readback(1'b1, 8'd1));

      // A new key stays out of entry zero until the next start-of-image.
      wait_idle();
      write_reg(CSR_KEY_COLOR, 15'h0000);
      send_item(pixel(1'b0, 8'h00, 8'h00, 8'h00));
      send_item(readback(1'b0, 8'd0));
      send_item(pixel(1'b1, 8'h00, 8'h00, 8'h00));

      wait_idle();
      write_reg(CSR_KEY_COLOR, 15'h7FFF);
      send_item(pixel(1'b1, 8'hFF, 8'hFF, 8'hFF));
      send_item(readback(1'b0, 8'd0));
      send_item(pixel(1'b0, 8'hFF, 8'h00, 8'h00));

      // Back in direct mode, readback still sees the palette, and a
      // conversion leaves it alone.
      wait_idle();
      write_reg(CSR_PALETTE_MODE, 15'd0);
      send_item(readback(1'b0, 8'd1));
      send_item(pixel(1'b0, 8'h01, 8'h02, 8'h03));

      // Random phases. Each phase starts with the sender paused until every
      // result is back, so the configuration can change safely.
      phase = 0;
      while (sent < ITEM_TARGET) begin
         fill = (phase == 2 || phase == 6);
         wait_idle();
         if (fill || phase == 0 || $urandom_range(0, 3) != 0) begin
            data    = COLOR_W'($urandom);
            data[0] = fill || phase == 0 || $urandom_range(0, 3) != 0;
            write_reg(CSR_PALETTE_MODE, data);
         end
         if (phase < 2 || $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 4))
               0:       data = '0;
               1:       data = '1;
               2:       data = KEY_RESET;
               default: data = COLOR_W'($urandom);
            endcase
            write_reg(CSR_KEY_COLOR, data);
         end
         steady = (phase % 4 == 3);
         if (phase == 0) begin
            // The receiver holds off long enough for the block to fill up
            // and drop req_ready while the sender keeps offering.
            steady    = 1'b1;
            hold_left = 400;
            run_image(30, 1'b1);
         end else if (fill) begin
            run_fill();
         end else begin
            run_image($urandom_range(20, 80), $urandom_range(0, 4) != 0);
         end
         steady = 1'b0;
         phase++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0 && book.awaited.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

/* rgb555_palette_indexer_top.f */
rtl/core/rpi_pkg.sv
rtl/core/rpi_ram.sv
rtl/core/rpi_csr.sv
rtl/core/rpi_engine.sv
rtl/core/rgb555_palette_indexer_top.sv
rtl/core/rpi_check.sv
tb/testbench.sv
